/* hw/rtl/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 character decoder.
// No dependencies; imported by every module of the decoder.
package utf8d_pkg;

  localparam int unsigned WIN_MAX   = 6;
  localparam int unsigned CONT_MAX  = WIN_MAX - 1;
  localparam int unsigned CP_W      = 31;
  localparam int unsigned CNT_W     = 3;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_ILLEGAL    = 2'd3
  } status_t;

  // Classification of one lead byte.
  typedef struct packed {
    logic             ascii;    // single byte character
    logic             bad;      // stray continuation byte, 0xFE or 0xFF
    logic [CNT_W-1:0] extra;    // continuation bytes that follow
    logic [6:0]       payload;  // code point bits carried by the lead
  } lead_info_t;

endpackage

/* hw/rtl/utf8d_lead.sv */
// Lead byte classifier for the UTF-8 character decoder.
// Depends on utf8d_pkg.
module utf8d_lead (
  input  logic [7:0]            lead,
  output utf8d_pkg::lead_info_t info
);
  import utf8d_pkg::*;

  // The position of the first zero bit below the top sets the length.
  always_comb begin
    info = '0;
    if (!lead[7]) begin
      info.ascii   = 1'b1;
      info.payload = lead[6:0];
    end else if (!lead[6]) begin
      info.bad = 1'b1;
    end else if (!lead[5]) begin
      info.extra   = CNT_W'(1);
      info.payload = {2'b00, lead[4:0]};
    end else if (!lead[4]) begin
      info.extra   = CNT_W'(2);
      info.payload = {3'b000, lead[3:0]};
    end else if (!lead[3]) begin
      info.extra   = CNT_W'(3);
      info.payload = {4'b0000, lead[2:0]};
    end else if (!lead[2]) begin
      info.extra   = CNT_W'(4);
      info.payload = {5'b00000, lead[1:0]};
    end else if (!lead[1]) begin
      info.extra   = CNT_W'(5);
      info.payload = {6'b000000, lead[0]};
    end else begin
      info.bad = 1'b1;
    end
  end

endmodule

/* hw/rtl/utf8_char_decoder.sv */
// Top level of the UTF-8 character decoder: three stage valid/ready pipeline.
// Depends on utf8d_pkg and utf8d_lead.
//
// The decoder takes one beat per clock: a window of six bytes plus a count of
// the bytes that are valid, and returns one beat per input beat giving the
// status, the code point and the number of bytes the character used. It
// accepts the original UTF-8 form with leads of up to six bytes, so code
// points reach 31 bits; overlong forms and surrogates are not rejected. A
// count of seven is treated as six. Stage one saturates the count and
// classifies the lead byte, stage two checks the continuation bytes and
// settles the status, and stage three assembles the code point into the
// output register. With out_ready held high the block sustains one beat per
// cycle; a stall on the output holds each full stage in place and in_ready
// drops only when all three stages are full.
module utf8_char_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte0,
  input  logic [7:0]                      in_byte1,
  input  logic [7:0]                      in_byte2,
  input  logic [7:0]                      in_byte3,
  input  logic [7:0]                      in_byte4,
  input  logic [7:0]                      in_byte5,
  input  logic [2:0]                      in_avail,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [utf8d_pkg::CP_W-1:0]      out_code_point,
  output logic [utf8d_pkg::CNT_W-1:0]     out_used_bytes
);
  import utf8d_pkg::*;

  // Stage readiness: a stage can load when it is empty or its content moves on.
  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, v3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---------------------------------------------------------------- stage 1
  // Saturate the count, classify the lead, and keep only the six payload bits
  // and the continuation tag of each following byte.
  lead_info_t               lead_info;
  logic [7:0]               win [1:CONT_MAX];
  logic [CNT_W-1:0]         avail_sat;

  utf8d_lead u_lead (
    .lead (in_byte0),
    .info (lead_info)
  );

  assign win[1] = in_byte1;
  assign win[2] = in_byte2;
  assign win[3] = in_byte3;
  assign win[4] = in_byte4;
  assign win[5] = in_byte5;
  assign avail_sat = (in_avail > CNT_W'(WIN_MAX)) ? CNT_W'(WIN_MAX) : in_avail;

  logic                     empty1_r;
  lead_info_t               info1_r;
  logic [CNT_W-1:0]         avail1_r;
  logic [CONT_MAX:1]        cont1_r;
  logic [5:0]               bits1_r [1:CONT_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      empty1_r <= (avail_sat == '0) || (in_byte0 == 8'h00);
      info1_r  <= lead_info;
      avail1_r <= avail_sat;
      for (int k = 1; k <= CONT_MAX; k++) begin
        cont1_r[k] <= (win[k] & CONT_MASK) == CONT_TAG;
        bits1_r[k] <= win[k][5:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  // A short window checks only the bytes it has after the lead; a full one
  // checks exactly the continuation bytes the lead asks for.
  logic             short2;
  logic [CNT_W-1:0] n_check;
  logic             cont_bad;
  status_t          status_nxt;
  logic [CNT_W-1:0] used_nxt;

  always_comb begin
    short2  = avail1_r <= info1_r.extra;
    n_check = short2 ? (avail1_r - CNT_W'(1)) : info1_r.extra;
    cont_bad = 1'b0;
    for (int k = 1; k <= CONT_MAX; k++) begin
      if ((CNT_W'(k) <= n_check) && !cont1_r[k]) begin
        cont_bad = 1'b1;
      end
    end

    used_nxt = '0;
    if (empty1_r) begin
      status_nxt = ST_EMPTY;
    end else if (info1_r.ascii) begin
      status_nxt = ST_VALID;
      used_nxt   = CNT_W'(1);
    end else if (info1_r.bad || cont_bad) begin
      status_nxt = ST_ILLEGAL;
    end else if (short2) begin
      status_nxt = ST_INCOMPLETE;
    end else begin
      status_nxt = ST_VALID;
      used_nxt   = info1_r.extra + CNT_W'(1);
    end
  end

  status_t          status2_r;
  logic [CNT_W-1:0] used2_r;
  logic [CNT_W-1:0] extra2_r;
  logic [6:0]       payload2_r;
  logic [5:0]       bits2_r [1:CONT_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      status2_r  <= status_nxt;
      used2_r    <= used_nxt;
      extra2_r   <= info1_r.extra;
      payload2_r <= info1_r.payload;
      for (int k = 1; k <= CONT_MAX; k++) begin
        bits2_r[k] <= bits1_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // The code point is the lead payload followed by six bits per continuation
  // byte; anything but a valid character reports zero.
  logic [CP_W-1:0] cp_nxt;

  always_comb begin
    cp_nxt = CP_W'(payload2_r);
    for (int k = 1; k <= CONT_MAX; k++) begin
      if (CNT_W'(k) <= extra2_r) begin
        cp_nxt = {cp_nxt[CP_W-7:0], bits2_r[k]};
      end
    end
    if (status2_r != ST_VALID) begin
      cp_nxt = '0;
    end
  end

  status_t          status3_r;
  logic [CP_W-1:0]  cp3_r;
  logic [CNT_W-1:0] used3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      status3_r <= status2_r;
      cp3_r     <= cp_nxt;
      used3_r   <= used2_r;
    end
  end

  assign out_valid      = v3_r;
  assign out_status     = status3_r;
  assign out_code_point = cp3_r;
  assign out_used_bytes = used3_r;

endmodule

/* hw/rtl/utf8d_checker.sv */
// Port-level checker for the UTF-8 character decoder, with its bind.
// Depends on utf8d_pkg and the utf8_char_decoder ports.
module utf8d_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_status,
  input logic [utf8d_pkg::CP_W-1:0]      out_code_point,
  input logic [utf8d_pkg::CNT_W-1:0]     out_used_bytes
);
  import utf8d_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_code_point) && $stable(out_used_bytes))
    else $error("result beat changed while stalled");

  // Anything but a valid character carries no code point and no length.
  a_nonvalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_VALID |-> out_code_point == '0 && out_used_bytes == '0)
    else $error("non-valid result carries data");

  // A valid character uses between one and six bytes.
  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_VALID |->
      out_used_bytes != '0 && out_used_bytes <= CNT_W'(WIN_MAX))
    else $error("valid result with bad length");

  // With the output draining, an accepted beat passes through the stage registers to the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 3) && $past(in_valid && in_ready, 3)
      && $past(out_ready, 1) && $past(out_ready, 2) |-> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind utf8_char_decoder utf8d_checker u_utf8d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_code_point (out_code_point),
  .out_used_bytes (out_used_bytes)
);
